FILE: rtl/core/euler_to_quaternion_top_defines.svh
// assertion macros shared by the euler_to_quaternion checker
// no dependencies; included by files that hold concurrent assertions
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define EUQ_ASSERT_NOW(lbl, clk, rstn, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define EUQ_ASSERT_NEXT(lbl, clk, rstn, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ant) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/euq_pkg.sv
// shared constants, arctangent table and helpers for euler_to_quaternion
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package euq_pkg;

  localparam int CORDIC_STAGES = 18;
  localparam int FRACTION_BITS = 16;
  localparam int IN_W          = 25;
  localparam int OUT_W         = 18;
  localparam int WORK_BITS     = 30;
  localparam int DEG_LIMIT     = 180;

  // cordic datapath widths
  localparam int XY_W    = 32;
  localparam int Z_W     = 33;
  localparam int STAGE_W = 5;

  // degree conversion: mag * round(pi/360 * 2^32), realigned from Q(frac) to Q30
  localparam int                MAG_W    = IN_W - 1;
  localparam logic [25:0]       HALF_RAD = 26'd37480660;
  localparam int                CONV_SH  = 32 - (WORK_BITS - FRACTION_BITS);
  localparam int                PROD_W   = MAG_W + 26 + 1;
  localparam logic [IN_W-1:0]   DEG_LIM  = IN_W'(DEG_LIMIT) << FRACTION_BITS;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

  // output rounding
  localparam int OUT_SH = WORK_BITS - FRACTION_BITS;

  // total pipeline latency: conversion, cordic cells, three combine stages
  localparam int LATENCY = 1 + CORDIC_STAGES + 3;

  // atan(2^-i) in Q30, truncated
  function automatic logic [Z_W-1:0] atan_q30(input logic [STAGE_W-1:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000007;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return {1'b0, v};
  endfunction

  // Q30 by Q30 product, rounded half up
  function automatic logic signed [XY_W-1:0] mul_q30(input logic signed [XY_W-1:0] a,
                                                     input logic signed [XY_W-1:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (WORK_BITS - 1));
    return XY_W'(p >>> WORK_BITS);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/euq_angle_conv.sv
// clamps one angle in degrees and converts its half angle to Q30 radians
// depends on euq_pkg
`timescale 1ns / 1ps
`default_nettype none

module euq_angle_conv (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire logic signed [euq_pkg::IN_W-1:0] deg_i,
  output logic signed [euq_pkg::Z_W-1:0]       half_rad_o
);
  import euq_pkg::*;

  logic              neg;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [Z_W-1:0]    t;
  logic signed [Z_W-1:0] half_rad_d, half_rad_q;

  // clamp to +/-180 degrees and take the magnitude
  always_comb begin
    neg = deg_i[IN_W-1];
    if (!neg && deg_i > $signed(DEG_LIM)) begin
      mag = MAG_W'(DEG_LIM);
    end else if (neg && deg_i < -$signed(DEG_LIM)) begin
      mag = MAG_W'(DEG_LIM);
    end else if (neg) begin
      mag = MAG_W'(-deg_i);
    end else begin
      mag = MAG_W'(deg_i);
    end
    prod = PROD_W'(mag) * PROD_W'(HALF_RAD) + (PROD_W'(1) << (CONV_SH - 1));
    t    = Z_W'(prod >> CONV_SH);
    half_rad_d = neg ? -$signed(t) : $signed(t);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      half_rad_q <= half_rad_d;
    end
  end

  assign half_rad_o = half_rad_q;

endmodule

`default_nettype wire

FILE: rtl/core/euq_cordic_cell.sv
// one rotation-mode cordic cell with a fixed shift given by its stage index
// depends on euq_pkg
`timescale 1ns / 1ps
`default_nettype none

module euq_cordic_cell (
  input  wire                                     clk_i,
  input  wire                                     en_i,
  input  wire logic [euq_pkg::STAGE_W-1:0]        stage_i,
  input  wire logic signed [euq_pkg::XY_W-1:0]    x_i,
  input  wire logic signed [euq_pkg::XY_W-1:0]    y_i,
  input  wire logic signed [euq_pkg::Z_W-1:0]     z_i,
  output logic signed [euq_pkg::XY_W-1:0]         x_o,
  output logic signed [euq_pkg::XY_W-1:0]         y_o,
  output logic signed [euq_pkg::Z_W-1:0]          z_o
);
  import euq_pkg::*;

  logic signed [XY_W-1:0] dx, dy, x_d, y_d, x_q, y_q;
  logic signed [Z_W-1:0]  z_d, z_q, ang;

  // rotate toward zero residual angle; zero counts as non-negative
  always_comb begin
    dx  = y_i >>> stage_i;
    dy  = x_i >>> stage_i;
    ang = $signed(atan_q30(stage_i));
    if (!z_i[Z_W-1]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - ang;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

`default_nettype wire

FILE: rtl/core/euq_quat_combine.sv
// forms the quaternion from three sine/cosine pairs in three registered stages
// depends on euq_pkg
`timescale 1ns / 1ps
`default_nettype none

module euq_quat_combine (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] sr_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] cr_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] sp_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] cp_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] sy_i,
  input  wire logic signed [euq_pkg::XY_W-1:0] cy_i,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_x_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_y_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_z_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_w_o
);
  import euq_pkg::*;

  typedef logic signed [XY_W-1:0] q30_t;
  typedef logic signed [OUT_W-1:0] qout_t;

  q30_t crcp_q, srsp_q, crsp_q, srcp_q, sy_q, cy_q;
  q30_t p_q [8];
  qout_t qx_q, qy_q, qz_q, qw_q;

  // round a Q30 sum to the output format and clamp to +/-1.0
  function automatic qout_t to_out(input logic signed [XY_W:0] s);
    logic signed [XY_W:0] v;
    logic signed [XY_W:0] one;
    one = (XY_W+1)'(1) <<< FRACTION_BITS;
    v   = (s + ((XY_W+1)'(1) <<< (OUT_SH - 1))) >>> OUT_SH;
    if (v > one) begin
      v = one;
    end else if (v < -one) begin
      v = -one;
    end
    return OUT_W'(v);
  endfunction

  // stage one: roll by pitch products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      crcp_q <= mul_q30(cr_i, cp_i);
      srsp_q <= mul_q30(sr_i, sp_i);
      crsp_q <= mul_q30(cr_i, sp_i);
      srcp_q <= mul_q30(sr_i, cp_i);
      sy_q   <= sy_i;
      cy_q   <= cy_i;
    end
  end

  // stage two: products with yaw
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q[0] <= mul_q30(srcp_q, cy_q);
      p_q[1] <= mul_q30(crsp_q, sy_q);
      p_q[2] <= mul_q30(crsp_q, cy_q);
      p_q[3] <= mul_q30(srcp_q, sy_q);
      p_q[4] <= mul_q30(crcp_q, sy_q);
      p_q[5] <= mul_q30(srsp_q, cy_q);
      p_q[6] <= mul_q30(crcp_q, cy_q);
      p_q[7] <= mul_q30(srsp_q, sy_q);
    end
  end

  // stage three: sums, rounding and clamping into the output register
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qx_q <= to_out((XY_W+1)'(p_q[0]) - (XY_W+1)'(p_q[1]));
      qy_q <= to_out((XY_W+1)'(p_q[2]) + (XY_W+1)'(p_q[3]));
      qz_q <= to_out((XY_W+1)'(p_q[4]) - (XY_W+1)'(p_q[5]));
      qw_q <= to_out((XY_W+1)'(p_q[6]) + (XY_W+1)'(p_q[7]));
    end
  end

  assign quat_x_o = qx_q;
  assign quat_y_o = qy_q;
  assign quat_z_o = qz_q;
  assign quat_w_o = qw_q;

endmodule

`default_nettype wire

FILE: rtl/core/euler_to_quaternion_top.sv
// Euler angles (roll, pitch, yaw in degrees, 16 fraction bits) to unit quaternion,
// fully pipelined: one pose is taken per clock while not paused, and each one
// passes one conversion stage, 18 cordic cells per angle, three product/sum stages.
// The whole pipeline advances together; it pauses only while the output register
// holds a beat that the sink has not taken; otherwise it moves one beat per cycle.
// depends on euq_pkg, euq_angle_conv, euq_cordic_cell, euq_quat_combine
`timescale 1ns / 1ps
`default_nettype none

module euler_to_quaternion_top (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic signed [euq_pkg::IN_W-1:0] roll_deg_i,
  input  wire logic signed [euq_pkg::IN_W-1:0] pitch_deg_i,
  input  wire logic signed [euq_pkg::IN_W-1:0] yaw_deg_i,
  output logic                                 out_valid_o,
  input  wire                                  out_ready_i,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_x_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_y_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_z_o,
  output logic signed [euq_pkg::OUT_W-1:0]     quat_w_o
);
  import euq_pkg::*;

  logic                en;
  logic [LATENCY-1:0]  valid_d, valid_q;
  logic signed [Z_W-1:0]  z_in [3];
  logic signed [XY_W-1:0] xs [3][CORDIC_STAGES+1];
  logic signed [XY_W-1:0] ys [3][CORDIC_STAGES+1];
  logic signed [Z_W-1:0]  zs [3][CORDIC_STAGES+1];

  // pipeline moves unless the output beat is stalled
  assign en         = !valid_q[LATENCY-1] || out_ready_i;
  assign in_ready_o = en;

  // valid chain alongside the datapath
  assign valid_d = {valid_q[LATENCY-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en) begin
      valid_q <= valid_d;
    end
  end

  // angle conversion, one per axis
  euq_angle_conv u_conv_roll  (.clk_i, .en_i(en), .deg_i(roll_deg_i),  .half_rad_o(z_in[0]));
  euq_angle_conv u_conv_pitch (.clk_i, .en_i(en), .deg_i(pitch_deg_i), .half_rad_o(z_in[1]));
  euq_angle_conv u_conv_yaw   (.clk_i, .en_i(en), .deg_i(yaw_deg_i),   .half_rad_o(z_in[2]));

  // three rows of cordic cells
  for (genvar a = 0; a < 3; a++) begin : g_axis
    assign xs[a][0] = CORDIC_GAIN;
    assign ys[a][0] = '0;
    assign zs[a][0] = z_in[a];
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
      euq_cordic_cell u_cell (
        .clk_i,
        .en_i    (en),
        .stage_i (STAGE_W'(s)),
        .x_i     (xs[a][s]),
        .y_i     (ys[a][s]),
        .z_i     (zs[a][s]),
        .x_o     (xs[a][s+1]),
        .y_o     (ys[a][s+1]),
        .z_o     (zs[a][s+1])
      );
    end
  end

  // products, sums and output register
  euq_quat_combine u_combine (
    .clk_i,
    .en_i     (en),
    .sr_i     (ys[0][CORDIC_STAGES]),
    .cr_i     (xs[0][CORDIC_STAGES]),
    .sp_i     (ys[1][CORDIC_STAGES]),
    .cp_i     (xs[1][CORDIC_STAGES]),
    .sy_i     (ys[2][CORDIC_STAGES]),
    .cy_i     (xs[2][CORDIC_STAGES]),
    .quat_x_o,
    .quat_y_o,
    .quat_z_o,
    .quat_w_o
  );

  assign out_valid_o = valid_q[LATENCY-1];

endmodule

`default_nettype wire

FILE: rtl/core/euq_checker.sv
// port-level checks for euler_to_quaternion_top, attached by bind
// depends on euq_pkg and euler_to_quaternion_top_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "euler_to_quaternion_top_defines.svh"

module euq_checker (
  input wire                                  clk_i,
  input wire                                  rst_ni,
  input wire                                  in_valid_i,
  input wire                                  in_ready_o,
  input wire                                  out_valid_o,
  input wire                                  out_ready_i,
  input wire logic signed [euq_pkg::OUT_W-1:0] quat_x_o,
  input wire logic signed [euq_pkg::OUT_W-1:0] quat_w_o
);
  import euq_pkg::*;

  // an empty output stage never blocks the input
  `EUQ_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")

  // a beat taken at the output frees the input in the same cycle
  `EUQ_ASSERT_NOW(a_ready_on_take, clk_i, rst_ni, out_valid_o && out_ready_i, in_ready_o, "input stalled while output drains")

  // stalled output beat holds
  `EUQ_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(quat_x_o) && $stable(quat_w_o), "output beat changed while stalled")

  // x and w components stay within +/-1.0
  `EUQ_ASSERT_NOW(a_range, clk_i, rst_ni, out_valid_o, (quat_w_o <= (OUT_W'(1) <<< FRACTION_BITS)) && (quat_w_o >= -(OUT_W'(1) <<< FRACTION_BITS)) && (quat_x_o <= (OUT_W'(1) <<< FRACTION_BITS)) && (quat_x_o >= -(OUT_W'(1) <<< FRACTION_BITS)), "component beyond unit range")

endmodule

bind euler_to_quaternion_top euq_checker u_euq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .quat_x_o    (quat_x_o),
  .quat_w_o    (quat_w_o)
);

`default_nettype wire
